// ----- sv/dtss_pkg.sv -----
package dtss_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TASK_W = 8;
  localparam int CNT_W  = 16;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_CREATE   = 2'd1,
    REQ_DISPATCH = 2'd2
  } req_e;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic [CNT_W-1:0]  countdown;
  } slot_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
  } mem_req_t;

endpackage

// ----- sv/dtss_slot_mem.sv -----
module dtss_slot_mem
  import dtss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output slot_t    rd_data_o
);

  slot_t              mem [SLOTS];
  logic [SLOTS-1:0]   written_q;
  slot_t              rd_q;
  logic               rd_written_q;

  // Write port and registered read port; the payload array needs no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // Per-entry written bits stand in for clearing the array at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written reads as a free slot with a zero countdown.
  assign rd_data_o = rd_written_q ? rd_q : '0;

endmodule

// ----- sv/delayed_task_slot_scheduler.sv -----
// Delayed task slot scheduler. The slot table (task id and 16-bit countdown per
// slot) sits in a single-port-read, single-port-write memory with a registered
// read port. Every request (tick, create, dispatch) is one input transaction
// and yields one output transaction: tdata carries the dispatched task (0 when
// none), tuser carries the accepted flag. Each request walks all SLOTS entries
// in order, reading one entry per cycle and writing back the entry read in the
// previous cycle; the next request is taken only once the result has entered
// the output register. A new request is accepted while the previous result
// still waits in the output register.
module delayed_task_slot_scheduler
  import dtss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] task_id, [23:8] delay_ticks
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] task_out
  output logic        m_axis_tuser_o   // [0] accepted
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              found_q, found_d;
  logic [TASK_W-1:0] res_task_q, res_task_d;
  logic [1:0]        req_q;
  logic [TASK_W-1:0] id_q;
  logic [CNT_W-1:0]  delay_q;

  logic              out_valid_q, out_valid_d;
  logic [TASK_W-1:0] out_task_q, out_task_d;
  logic              out_acc_q, out_acc_d;

  logic     in_fire;
  logic     out_free;
  mem_req_t mem_req;
  slot_t    entry;

  dtss_slot_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(entry)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    found_d     = found_q;
    res_task_d  = res_task_q;
    out_valid_d = out_valid_q;
    out_task_d  = out_task_q;
    out_acc_d   = out_acc_q;
    mem_req     = '0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = '0;
          idx_d           = '0;
          found_d         = 1'b0;
          res_task_d      = '0;
          state_d         = S_WALK;
        end
      end
      S_WALK: begin
        // Prefetch the next entry while the current one is modified.
        mem_req.rd_en   = (idx_q != LAST_SLOT);
        mem_req.rd_addr = idx_q + 1'b1;
        mem_req.wr_addr = idx_q;
        mem_req.wr_data = entry;
        case (req_e'(req_q))
          REQ_TICK: begin
            if (entry.countdown != '0) begin
              mem_req.wr_en             = 1'b1;
              mem_req.wr_data.countdown = entry.countdown - 1'b1;
            end
          end
          REQ_CREATE: begin
            if (!found_q && entry.tid == '0) begin
              mem_req.wr_en             = 1'b1;
              mem_req.wr_data.tid       = id_q;
              mem_req.wr_data.countdown = delay_q;
              found_d                   = 1'b1;
            end
          end
          REQ_DISPATCH: begin
            if (!found_q && entry.tid != '0 && entry.countdown == '0) begin
              mem_req.wr_en       = 1'b1;
              mem_req.wr_data.tid = '0;
              found_d             = 1'b1;
              res_task_d          = entry.tid;
            end
          end
          default: begin
          end
        endcase
        if (idx_q == LAST_SLOT) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          out_valid_d = 1'b1;
          case (req_e'(req_q))
            REQ_TICK: begin
              out_task_d = '0;
              out_acc_d  = 1'b1;
            end
            REQ_CREATE: begin
              out_task_d = '0;
              out_acc_d  = found_q;
            end
            REQ_DISPATCH: begin
              out_task_d = res_task_q;
              out_acc_d  = 1'b1;
            end
            default: begin
              out_task_d = '0;
              out_acc_d  = 1'b0;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_task_q <= res_task_d;
    out_task_q <= out_task_d;
    out_acc_q  <= out_acc_d;
    if (in_fire) begin
      req_q   <= s_axis_tuser_i;
      id_q    <= s_axis_tdata_i[TASK_W-1:0];
      delay_q <= s_axis_tdata_i[TASK_W+CNT_W-1:TASK_W];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_task_q;
  assign m_axis_tuser_o  = out_acc_q;

endmodule
